[hw/rtl/sldl_pkg.sv]
// Package for the sorted list block.
// Holds field widths, request opcodes and result status codes; no dependencies.
package sldl_pkg;

  // Field widths of the request and result channels.
  localparam int OpW     = 2;
  localparam int ValueW  = 32;
  localparam int PosW    = 6;
  localparam int StatusW = 2;

  // Default table depth.
  localparam int DefCapacity = 64;

  // Request opcodes.
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_READ   = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD_POS   = 2'd3;

endpackage

[hw/rtl/sorted_list_insert_delete.sv]
// Sorted list block: a table of signed values kept in ascending order.
// Depends on sldl_pkg for widths, opcodes and status codes.
//
// Usage: a request (opcode, value, position) enters on in_valid_i when
// in_stall_o is low. Opcode insert places the value in order, delete removes
// one copy of it, and read returns the entry at a position. Every request
// gives one result (status, read_value, entry_count) on out_valid_o, taken
// when out_stall_i is low. An unused opcode gives status ok and changes
// nothing.
// The entries sit in a single-port-write, registered-read memory that one
// sequencer walks one entry per cycle, so the memory port sets the timing.
// An insert moves each larger entry up one slot from the top down, a delete
// scans for the first match and moves the later entries down, and a read
// waits on the registered port. One request is in work at a time and
// in_stall_o stays high until its result has moved to the output register.
// The output register holds a finished result while the receiver stalls, and
// the next request is taken meanwhile; it finishes only once that slot frees.
// Reset clears the count and the handshake state; the memory is not cleared,
// since only entries below the count are ever read.
module sorted_list_insert_delete #(
  parameter int CAPACITY = sldl_pkg::DefCapacity,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sldl_pkg::OpW-1:0]          opcode_i,
  input  logic signed [sldl_pkg::ValueW-1:0] value_i,
  input  logic [sldl_pkg::PosW-1:0]         position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sldl_pkg::StatusW-1:0]      status_o,
  output logic signed [sldl_pkg::ValueW-1:0] read_value_o,
  output logic [CntW-1:0]                   entry_count_o
);

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CmpW  = (sldl_pkg::PosW > CntW) ? sldl_pkg::PosW : CntW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_CMP   = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_DEL_SCAN  = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_RD_WAIT   = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]                        state_q, state_d;
  logic [CntW-1:0]                   count_q, count_d;
  logic [AddrW-1:0]                  idx_q, idx_d;
  logic signed [sldl_pkg::ValueW-1:0] val_q, val_d;
  logic [sldl_pkg::PosW-1:0]         pos_q, pos_d;
  logic [sldl_pkg::StatusW-1:0]      res_status_q, res_status_d;
  logic [sldl_pkg::ValueW-1:0]       res_value_q, res_value_d;

  logic                              out_valid_q, out_valid_d;
  logic [sldl_pkg::StatusW-1:0]      out_status_q, out_status_d;
  logic [sldl_pkg::ValueW-1:0]       out_value_q, out_value_d;
  logic [CntW-1:0]                   out_count_q, out_count_d;

  logic [sldl_pkg::ValueW-1:0]       mem_q [CAPACITY];
  logic [sldl_pkg::ValueW-1:0]       rd_data_q;
  logic [AddrW-1:0]                  rd_addr;
  logic [AddrW-1:0]                  wr_addr;
  logic [sldl_pkg::ValueW-1:0]       wr_data;
  logic                              mem_we;

  logic                              in_fire;
  logic                              out_free;
  logic [CntW-1:0]                   idx_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_ext    = CntW'(idx_q);

  // Entry memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer: walks the table one entry per cycle.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    val_d        = val_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    rd_addr      = '0;
    wr_addr      = idx_q;
    wr_data      = val_q;
    mem_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        rd_addr = (opcode_i == sldl_pkg::OP_READ) ? AddrW'(position_i) : '0;
        if (in_fire) begin
          val_d        = value_i;
          pos_d        = position_i;
          res_status_d = sldl_pkg::ST_OK;
          res_value_d  = '0;
          priority if (opcode_i == sldl_pkg::OP_INSERT) begin
            if (count_q >= CntW'(CAPACITY)) begin
              res_status_d = sldl_pkg::ST_FULL;
              state_d      = S_DONE;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_PUT;
            end else begin
              idx_d   = AddrW'(count_q);
              rd_addr = AddrW'(count_q - CntW'(1));
              state_d = S_INS_CMP;
            end
          end else if (opcode_i == sldl_pkg::OP_DELETE) begin
            idx_d = '0;
            if (count_q == '0) begin
              res_status_d = sldl_pkg::ST_NOT_FOUND;
              state_d      = S_DONE;
            end else begin
              state_d = S_DEL_SCAN;
            end
          end else if (opcode_i == sldl_pkg::OP_READ) begin
            state_d = S_RD_WAIT;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // Insert: move larger entries up one slot, from the top down.
      S_INS_CMP: begin
        mem_we = 1'b1;
        if ($signed(rd_data_q) > val_q) begin
          wr_data = rd_data_q;
          idx_d   = idx_q - AddrW'(1);
          if (idx_q == AddrW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            rd_addr = idx_q - AddrW'(2);
          end
        end else begin
          count_d = count_q + CntW'(1);
          state_d = S_DONE;
        end
      end

      S_INS_PUT: begin
        mem_we  = 1'b1;
        count_d = count_q + CntW'(1);
        state_d = S_DONE;
      end

      // Delete: find the first matching entry.
      S_DEL_SCAN: begin
        if (rd_data_q == val_q) begin
          if (idx_ext + CntW'(1) == count_q) begin
            count_d = count_q - CntW'(1);
            state_d = S_DONE;
          end else begin
            rd_addr = AddrW'(idx_ext + CntW'(1));
            state_d = S_DEL_SHIFT;
          end
        end else if (idx_ext + CntW'(1) == count_q) begin
          res_status_d = sldl_pkg::ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          idx_d   = idx_q + AddrW'(1);
          rd_addr = AddrW'(idx_ext + CntW'(1));
        end
      end

      // Delete: move the following entries down one slot.
      S_DEL_SHIFT: begin
        mem_we  = 1'b1;
        wr_data = rd_data_q;
        idx_d   = idx_q + AddrW'(1);
        if (idx_ext + CntW'(2) == count_q) begin
          count_d = count_q - CntW'(1);
          state_d = S_DONE;
        end else begin
          rd_addr = AddrW'(idx_ext + CntW'(2));
        end
      end

      // Read: the registered port gives the entry in the cycle after its address.
      S_RD_WAIT: begin
        if (CmpW'(pos_q) < CmpW'(count_q)) begin
          res_value_d = rd_data_q;
        end else begin
          res_status_d = sldl_pkg::ST_BAD_POS;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loads a finished result once the slot is free.
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    if (state_q == S_DONE && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_value_d  = res_value_q;
      out_count_d  = count_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_value_q;
  assign entry_count_o = out_count_q;

endmodule

[verif/sldl_list_checker.sv]
// Checker for the sorted list block: watches both channels, predicts each result and compares.
// Depends on sldl_pkg for field widths, opcodes and status codes.
module sldl_list_checker #(
  parameter int CAPACITY = sldl_pkg::DefCapacity,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [sldl_pkg::OpW-1:0]           opcode_i,
  input  logic signed [sldl_pkg::ValueW-1:0] value_i,
  input  logic [sldl_pkg::PosW-1:0]          position_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [sldl_pkg::StatusW-1:0]       status_i,
  input  logic signed [sldl_pkg::ValueW-1:0] read_value_i,
  input  logic [CntW-1:0]                    entry_count_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [sldl_pkg::StatusW-1:0]       status;
    logic signed [sldl_pkg::ValueW-1:0] read_value;
    logic [CntW-1:0]                    count;
  } list_result_t;

  // Shadow copy of the table, ascending in slots below held_count.
  logic signed [sldl_pkg::ValueW-1:0] sorted_vals [CAPACITY];
  int                                 held_count = 0;
  list_result_t                       results_due [$];
  int                                 mismatches = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = results_due.size();

  // Apply one request to the shadow table and return the result it should give.
  function automatic list_result_t apply_request(
    input logic [sldl_pkg::OpW-1:0]           op,
    input logic signed [sldl_pkg::ValueW-1:0] val,
    input logic [sldl_pkg::PosW-1:0]          pos);
    list_result_t res;
    int           slot;
    res.status     = sldl_pkg::ST_OK;
    res.read_value = '0;
    slot           = 0;
    case (op)
      sldl_pkg::OP_INSERT: begin
        if (held_count >= CAPACITY) begin
          res.status = sldl_pkg::ST_FULL;
        end else begin
          // New value goes before the first entry that is not smaller.
          while (slot < held_count && sorted_vals[slot] < val) slot++;
          for (int i = held_count; i > slot; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[slot] = val;
          held_count++;
        end
      end
      sldl_pkg::OP_DELETE: begin
        while (slot < held_count && sorted_vals[slot] != val) slot++;
        if (slot >= held_count) begin
          res.status = sldl_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < held_count; i++) sorted_vals[i] = sorted_vals[i+1];
          held_count--;
        end
      end
      sldl_pkg::OP_READ: begin
        if (int'(pos) < held_count) begin
          res.read_value = sorted_vals[pos];
        end else begin
          res.status = sldl_pkg::ST_BAD_POS;
        end
      end
      default: begin
        // Unused opcode leaves the table alone.
      end
    endcase
    res.count = CntW'(held_count);
    return res;
  endfunction

  // Count a failure; only the first few get printed.
  task automatic log_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] sorted list mismatch: %s", $time, what);
  endtask

  // Results are checked before requests are applied, so nothing can match a
  // prediction made at the same edge.
  always @(posedge clk_i) begin
    list_result_t due;
    if (!rst_ni) begin
      held_count = 0;
      results_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          log_failure($sformatf("unexpected result status=%0d read_value=%0d count=%0d",
                                status_i, read_value_i, entry_count_i));
        end else begin
          due = results_due.pop_front();
          if (status_i !== due.status || read_value_i !== due.read_value ||
              entry_count_i !== due.count) begin
            log_failure($sformatf(
              "expected status=%0d read_value=%0d count=%0d, got status=%0d read_value=%0d count=%0d",
              due.status, due.read_value, due.count, status_i, read_value_i, entry_count_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(apply_request(opcode_i, value_i, position_i));
      end
    end
  end

endmodule

[verif/sorted_list_insert_delete_tb.sv]
// Testbench top for the sorted list block: clock, reset, request traffic and verdict.
// Depends on sldl_pkg, sorted_list_insert_delete and the sldl_list_checker module.
module sorted_list_insert_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity   = sldl_pkg::DefCapacity;
  localparam int CntW       = $clog2(Capacity + 1);
  localparam int ItemCount  = 1000;
  localparam int CycleLimit = 1000000;

  // Opcode the block does not use; it must still give a result.
  localparam logic [sldl_pkg::OpW-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [sldl_pkg::ValueW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [sldl_pkg::ValueW-1:0] MaxValue = 32'sh7fff_ffff;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_e;

  logic                               clk_i      = 1'b0;
  logic                               rst_ni     = 1'b0;
  logic                               in_valid   = 1'b0;
  logic                               in_stall;
  logic [sldl_pkg::OpW-1:0]           opcode     = sldl_pkg::OP_INSERT;
  logic signed [sldl_pkg::ValueW-1:0] value      = '0;
  logic [sldl_pkg::PosW-1:0]          position   = '0;
  logic                               out_valid;
  logic                               out_stall  = 1'b0;
  logic [sldl_pkg::StatusW-1:0]       status;
  logic signed [sldl_pkg::ValueW-1:0] read_value;
  logic [CntW-1:0]                    entry_count;
  int                                 fail_count;
  int                                 pending;

  int                                 burst_left = 0;
  int                                 cycle_count;
  logic signed [sldl_pkg::ValueW-1:0] insert_pool [$];
  rx_mode_e                           rx_mode    = RX_FREE;
  int                                 rx_left    = 0;

  always #2 clk_i = ~clk_i;

  sorted_list_insert_delete #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .value_i      (value),
    .position_i   (position),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .read_value_o (read_value),
    .entry_count_o(entry_count)
  );

  sldl_list_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .value_i      (value),
    .position_i   (position),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .read_value_i (read_value),
    .entry_count_i(entry_count),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver stalls in modes that change at random: free, light, heavy and bursty.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
      RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
      default:   out_stall <= ((rx_left % 16) < 10);
    endcase
  end

  // Present one request, hold it until taken, then maybe pause between bursts.
  task automatic send_request(input logic [sldl_pkg::OpW-1:0]           op,
                              input logic signed [sldl_pkg::ValueW-1:0] val,
                              input logic [sldl_pkg::PosW-1:0]          pos);
    int gap;
    opcode   <= op;
    value    <= val;
    position <= pos;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (op == sldl_pkg::OP_INSERT) begin
      insert_pool.push_back(val);
      if (insert_pool.size() > Capacity) void'(insert_pool.pop_front());
    end
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Values lean on the extremes and a small range so duplicates and hits are common.
  function automatic logic signed [sldl_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MinValue;
      1:       return MaxValue;
      2, 3, 4: return sldl_pkg::ValueW'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Deletes mostly name a value that was inserted recently.
  function automatic logic signed [sldl_pkg::ValueW-1:0] pick_delete_value();
    if (insert_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
      return insert_pool[$urandom_range(0, insert_pool.size() - 1)];
    end
    return pick_value();
  endfunction

  // One request of a random mix with the given share of inserts in percent.
  task automatic send_random(input int insert_share);
    logic [sldl_pkg::PosW-1:0] pos;
    int                        pick;
    pos  = ($urandom_range(0, 1) == 0) ? sldl_pkg::PosW'($urandom_range(0, 15)) :
                                         sldl_pkg::PosW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < insert_share) begin
      send_request(sldl_pkg::OP_INSERT, pick_value(), pos);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_request(OP_UNUSED, pick_value(), pos);
      end else if (pick < 45) begin
        send_request(sldl_pkg::OP_READ, pick_value(), pos);
      end else begin
        send_request(sldl_pkg::OP_DELETE, pick_delete_value(), pos);
      end
    end
  endtask

  // Timeout watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** sorted_list_insert_delete: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed requests, random phases, drain and verdict.
  initial begin
    int sent;
    int phase_len;
    int insert_share;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: read and delete both miss; the unused opcode does nothing.
    send_request(sldl_pkg::OP_READ, '0, '0);
    send_request(sldl_pkg::OP_DELETE, 32'sd5, '0);
    send_request(OP_UNUSED, '0, '0);
    // Extremes, a duplicate pair and neighbors of zero.
    send_request(sldl_pkg::OP_INSERT, MaxValue, '0);
    send_request(sldl_pkg::OP_INSERT, MinValue, '0);
    send_request(sldl_pkg::OP_INSERT, 32'sd0, '0);
    send_request(sldl_pkg::OP_INSERT, 32'sd0, '0);
    send_request(sldl_pkg::OP_INSERT, -32'sd1, '0);
    send_request(sldl_pkg::OP_INSERT, 32'sd1, '0);
    for (int p = 0; p < 6; p++) send_request(sldl_pkg::OP_READ, '0, sldl_pkg::PosW'(p));
    // Reads past the count, including the top position.
    send_request(sldl_pkg::OP_READ, '0, 6'd6);
    send_request(sldl_pkg::OP_READ, MaxValue, 6'd63);
    // Delete one copy of a duplicate, a missing value, then both extremes.
    send_request(sldl_pkg::OP_DELETE, 32'sd0, '0);
    send_request(sldl_pkg::OP_READ, '0, 6'd1);
    send_request(sldl_pkg::OP_DELETE, 32'sd7, '0);
    send_request(sldl_pkg::OP_DELETE, MinValue, '0);
    send_request(sldl_pkg::OP_DELETE, MaxValue, '0);
    send_request(OP_UNUSED, MinValue, 6'd63);

    // Random phases; the first one fills the table past capacity.
    sent = 0;
    insert_share = 95;
    phase_len = 110;
    while (sent < ItemCount) begin
      for (int k = 0; k < phase_len && sent < ItemCount; k++) begin
        send_random(insert_share);
        sent++;
      end
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       insert_share = 90;
        1:       insert_share = 60;
        2:       insert_share = 35;
        default: insert_share = 10;
      endcase
    end

    // Drain: wait for every result, then a little longer for strays.
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Capacity + 16) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("** sorted_list_insert_delete: PASSED **");
    end else begin
      $display("** sorted_list_insert_delete: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sldl_pkg.sv
hw/rtl/sorted_list_insert_delete.sv
verif/sldl_list_checker.sv
verif/sorted_list_insert_delete_tb.sv
